FILE: rtl/rc6_pkg.sv
package rc6_pkg;

  localparam int MAX_ROUNDS    = 20;
  localparam int MAX_KEY_BYTES = 32;
  localparam int WORD_W        = 32;
  localparam int ROT_W         = $clog2(WORD_W);

  // configuration port
  localparam int KEY_PAIRS  = 4;
  localparam int PAIR_REG_W = 64;
  localparam int LEN_W      = 6;
  localparam int RC_W       = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = PAIR_REG_W;

  // magic constants from the golden ratio and e
  localparam logic [WORD_W-1:0] P32 = 32'hB7E15163;
  localparam logic [WORD_W-1:0] Q32 = 32'h9E3779B9;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic {
    FUNC_ENC = 1'b0,
    FUNC_DEC = 1'b1
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LOW    = 3'd0,
    CFG_KEY_SECOND = 3'd1,
    CFG_KEY_THIRD  = 3'd2,
    CFG_KEY_HIGH   = 3'd3,
    CFG_KEY_LEN    = 3'd4,
    CFG_ROUNDS     = 3'd5
  } cfg_reg_t;

  function automatic word_t rotl32(input word_t x, input logic [ROT_W-1:0] n);
    logic [2*WORD_W-1:0] d;
    d = {x, x} << n;
    return d[2*WORD_W-1:WORD_W];
  endfunction

  function automatic word_t rotr32(input word_t x, input logic [ROT_W-1:0] n);
    logic [2*WORD_W-1:0] d;
    d = {x, x} >> n;
    return d[WORD_W-1:0];
  endfunction

  // x * (2x + 1) mod 2^32, then rotate left by log2 of the word size
  function automatic word_t quad_mix(input word_t x);
    word_t m;
    m = x * ((x << 1) | word_t'(1));
    return rotl32(m, ROT_W'(ROT_W));
  endfunction

endpackage

FILE: rtl/rc6_in_if.sv
interface rc6_in_if;
  import rc6_pkg::*;

  logic  valid;
  logic  ready;
  logic  func;
  word_t word_a;
  word_t word_b;
  word_t word_c;
  word_t word_d;

  modport source (output valid, func, word_a, word_b, word_c, word_d, input ready);
  modport sink   (input valid, func, word_a, word_b, word_c, word_d, output ready);

endinterface

FILE: rtl/rc6_out_if.sv
interface rc6_out_if;
  import rc6_pkg::*;

  logic  valid;
  logic  ready;
  word_t out_a;
  word_t out_b;
  word_t out_c;
  word_t out_d;

  modport source (output valid, out_a, out_b, out_c, out_d, input ready);
  modport sink   (input valid, out_a, out_b, out_c, out_d, output ready);

endinterface

FILE: rtl/rc6_block_cipher.sv
// rc6 block cipher, 32-bit words, one shared round unit stepped by a small sequencer
// with keys in place, a block steps through a whitening state, a mix state and a round
// state per round, and an output state; a new block is taken only once the output state
// has loaded its result, which waits while an untaken result holds the output register
// first block after reset or a key, key length or round count write runs the key schedule first, t = 2r+4
// reset: sequencer idle, keys invalid, config at defaults; round key memory is not cleared
module rc6_block_cipher (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [rc6_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rc6_pkg::CFG_DATA_W-1:0]   cfg_data,
  rc6_in_if.sink                           blk,
  rc6_out_if.source                        res
);
  import rc6_pkg::*;

  // round key store is split into even and odd banks so a round reads both keys at once
  localparam int RK_PAIRS    = MAX_ROUNDS + 2;
  localparam int PAIR_W      = $clog2(RK_PAIRS);
  localparam int RK_IDX_W    = PAIR_W + 1;
  localparam int RK_DEPTH    = 2 * RK_PAIRS;
  localparam int T_W         = $clog2(RK_DEPTH + 1);
  localparam int KW_DEPTH    = (MAX_KEY_BYTES + 3) / 4;
  localparam int KW_IDX_W    = (KW_DEPTH > 1) ? $clog2(KW_DEPTH) : 1;
  localparam int KC_W        = $clog2(KW_DEPTH + 1);
  localparam int BL_W        = LEN_W + 1;
  localparam int RC_CMP_W    = RC_W + 1;
  localparam int MIX_MAX     = (KW_DEPTH > RK_DEPTH) ? KW_DEPTH : RK_DEPTH;
  localparam int V_W         = $clog2(3 * MIX_MAX + 1);
  localparam int KEY_VEC_W   = KEY_PAIRS * PAIR_REG_W;
  localparam int KEY_EXT_W   = 4 * 8 * KW_DEPTH;

  typedef enum logic [3:0] {
    IDLE,
    KS_INIT,
    KS_RD,
    KS_A,
    KS_B,
    WHITE,
    MIX,
    ROUND,
    FIN
  } state_t;

  // control and configuration
  state_t                  state;
  logic                    keys_ready;
  logic                    res_valid;
  logic [PAIR_REG_W-1:0]   key_pair [KEY_PAIRS];
  logic [LEN_W-1:0]        key_len;
  logic [RC_W-1:0]         round_count;
  logic [RK_IDX_W-1:0]     ks_i;
  logic [KW_IDX_W-1:0]     kj;
  logic [V_W-1:0]          ks_step;
  logic [PAIR_W-1:0]       rnd;

  // datapath
  func_t                   func_q;
  word_t                   wa, wb, wc, wd;
  word_t                   t_q, u_q;
  word_t                   ks_a, ks_b;
  word_t                   prun;
  word_t                   key_work [KW_DEPTH];
  word_t                   res_a, res_b, res_c, res_d;

  // round key memory
  word_t                   rk_even [RK_PAIRS];
  word_t                   rk_odd  [RK_PAIRS];
  word_t                   rk_even_q, rk_odd_q;
  logic [PAIR_W-1:0]       kaddr;
  logic                    rk_we;
  word_t                   rk_wdata;

  // derived lengths
  logic [PAIR_W-1:0]       rounds;
  logic [PAIR_W-1:0]       rk_hi_pair;
  logic [T_W-1:0]          t_len;
  logic [RK_IDX_W-1:0]     ks_i_end;
  logic [BL_W-1:0]         b_eff;
  logic [BL_W-1:0]         b_round;
  logic [KC_W-1:0]         kw_cnt;
  logic [V_W-1:0]          mix_len;
  logic [V_W-1:0]          v_len;

  logic                    blk_acc;
  logic                    res_load;
  func_t                   func_in;
  logic                    enc;
  logic                    rnd_last;
  logic                    ks_last;
  logic [RK_IDX_W-1:0]     ks_inext;
  logic [KW_IDX_W-1:0]     kj_next;
  logic [KEY_VEC_W-1:0]    key_vec;
  logic [KEY_EXT_W-1:0]    key_ext;
  word_t                   kw_init [KW_DEPTH];
  word_t                   rk_sel;
  word_t                   ks_anew;
  word_t                   ks_mix;
  word_t                   ks_bnew;
  word_t                   enc_a, enc_c, dec_a, dec_c;

  // handshakes: a block is taken only while the sequencer is idle; the output
  // register lets a finished result wait while the next block is taken
  assign blk.ready = (state == IDLE);
  assign blk_acc   = blk.valid && blk.ready;
  assign res_load  = (state == FIN) && (!res_valid || res.ready);
  assign res.valid = res_valid;
  assign res.out_a = res_a;
  assign res.out_b = res_b;
  assign res.out_c = res_c;
  assign res.out_d = res_d;

  assign func_in = func_t'(blk.func);
  assign enc     = (func_q == FUNC_ENC);

  // round count saturates to 1..MAX_ROUNDS
  always_comb begin
    if (round_count == '0) begin
      rounds = PAIR_W'(1);
    end else if ({1'b0, round_count} > RC_CMP_W'(MAX_ROUNDS)) begin
      rounds = PAIR_W'(MAX_ROUNDS);
    end else begin
      rounds = PAIR_W'(round_count);
    end
  end

  assign rk_hi_pair = rounds + PAIR_W'(1);
  assign t_len      = T_W'({rounds, 1'b0}) + T_W'(4);
  assign ks_i_end   = RK_IDX_W'(t_len - T_W'(1));

  // key length saturates; an empty key still gives one zero word
  assign b_eff   = ({1'b0, key_len} > BL_W'(MAX_KEY_BYTES)) ? BL_W'(MAX_KEY_BYTES)
                                                             : {1'b0, key_len};
  assign b_round = b_eff + BL_W'(3);
  assign kw_cnt  = (b_round[BL_W-1:2] == '0) ? KC_W'(1) : KC_W'(b_round[BL_W-1:2]);
  assign mix_len = (V_W'(kw_cnt) > V_W'(t_len)) ? V_W'(kw_cnt) : V_W'(t_len);
  assign v_len   = mix_len + V_W'({mix_len, 1'b0});

  assign ks_last  = (ks_step == v_len - V_W'(1));
  assign ks_inext = (ks_i == ks_i_end) ? '0 : ks_i + RK_IDX_W'(1);
  assign kj_next  = (KC_W'(kj) + KC_W'(1) == kw_cnt) ? '0 : kj + KW_IDX_W'(1);
  assign rnd_last = enc ? (rnd == rounds) : (rnd == PAIR_W'(1));

  // key bytes beyond the register file read as zero, bytes past the length are masked
  always_comb begin
    for (int p = 0; p < KEY_PAIRS; p++) begin
      key_vec[p*PAIR_REG_W +: PAIR_REG_W] = key_pair[p];
    end
    key_ext = KEY_EXT_W'(key_vec);
    for (int jj = 0; jj < KW_DEPTH; jj++) begin
      for (int kk = 0; kk < 4; kk++) begin
        kw_init[jj][8*kk +: 8] = (BL_W'(4*jj + kk) < b_eff) ? key_ext[8*(4*jj + kk) +: 8]
                                                            : 8'h00;
      end
    end
  end

  // key schedule mixing unit
  assign rk_sel  = ks_i[0] ? rk_odd_q : rk_even_q;
  assign ks_anew = rotl32(rk_sel + ks_a + ks_b, ROT_W'(3));
  assign ks_mix  = ks_a + ks_b;
  assign ks_bnew = rotl32(key_work[kj] + ks_mix, ks_mix[ROT_W-1:0]);

  // shared round unit, forward and inverse
  assign enc_a = rotl32(wa ^ t_q, u_q[ROT_W-1:0]) + rk_even_q;
  assign enc_c = rotl32(wc ^ u_q, t_q[ROT_W-1:0]) + rk_odd_q;
  assign dec_c = rotr32(wc - rk_odd_q, t_q[ROT_W-1:0]) ^ u_q;
  assign dec_a = rotr32(wa - rk_even_q, u_q[ROT_W-1:0]) ^ t_q;

  // key pair address, issued in the cycle before the bank outputs are used
  always_comb begin
    case (state)
      IDLE:    kaddr = (func_in == FUNC_ENC) ? '0 : rk_hi_pair;
      KS_RD:   kaddr = ks_i[RK_IDX_W-1:1];
      KS_B: begin
        if (ks_last) begin
          kaddr = enc ? '0 : rk_hi_pair;
        end else begin
          kaddr = ks_inext[RK_IDX_W-1:1];
        end
      end
      MIX:     kaddr = rnd;
      ROUND:   kaddr = enc ? rk_hi_pair : '0;
      FIN:     kaddr = enc ? rk_hi_pair : '0;
      default: kaddr = '0;
    endcase
  end

  assign rk_we    = (state == KS_INIT) || (state == KS_A);
  assign rk_wdata = (state == KS_INIT) ? prun : ks_anew;

  always_ff @(posedge clk) begin
    if (rk_we && !ks_i[0]) begin
      rk_even[ks_i[RK_IDX_W-1:1]] <= rk_wdata;
    end
    rk_even_q <= rk_even[kaddr];
  end

  always_ff @(posedge clk) begin
    if (rk_we && ks_i[0]) begin
      rk_odd[ks_i[RK_IDX_W-1:1]] <= rk_wdata;
    end
    rk_odd_q <= rk_odd[kaddr];
  end

  // sequencer, configuration registers and output beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      keys_ready  <= 1'b0;
      res_valid   <= 1'b0;
      for (int p = 0; p < KEY_PAIRS; p++) begin
        key_pair[p] <= '0;
      end
      key_len     <= LEN_W'(16);
      round_count <= RC_W'(20);
      ks_i        <= '0;
      kj          <= '0;
      ks_step     <= '0;
      rnd         <= '0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (blk_acc) begin
            if (keys_ready) begin
              state <= WHITE;
            end else begin
              ks_i    <= '0;
              kj      <= '0;
              ks_step <= '0;
              state   <= KS_INIT;
            end
          end
        end
        KS_INIT: begin
          if (ks_i == ks_i_end) begin
            ks_i  <= '0;
            state <= KS_RD;
          end else begin
            ks_i <= ks_i + RK_IDX_W'(1);
          end
        end
        KS_RD: state <= KS_A;
        KS_A:  state <= KS_B;
        KS_B: begin
          ks_i    <= ks_inext;
          kj      <= kj_next;
          ks_step <= ks_step + V_W'(1);
          if (ks_last) begin
            keys_ready <= 1'b1;
            state      <= WHITE;
          end else begin
            state <= KS_A;
          end
        end
        WHITE: begin
          rnd   <= enc ? PAIR_W'(1) : rounds;
          state <= MIX;
        end
        MIX: state <= ROUND;
        ROUND: begin
          if (rnd_last) begin
            state <= FIN;
          end else begin
            rnd   <= enc ? rnd + PAIR_W'(1) : rnd - PAIR_W'(1);
            state <= MIX;
          end
        end
        FIN: begin
          if (res_load) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase

      // key, key length or round count change invalidates the schedule
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_KEY_LOW: begin
            key_pair[0] <= cfg_data;
            keys_ready  <= 1'b0;
          end
          CFG_KEY_SECOND: begin
            key_pair[1] <= cfg_data;
            keys_ready  <= 1'b0;
          end
          CFG_KEY_THIRD: begin
            key_pair[2] <= cfg_data;
            keys_ready  <= 1'b0;
          end
          CFG_KEY_HIGH: begin
            key_pair[3] <= cfg_data;
            keys_ready  <= 1'b0;
          end
          CFG_KEY_LEN: begin
            key_len    <= cfg_data[LEN_W-1:0];
            keys_ready <= 1'b0;
          end
          CFG_ROUNDS: begin
            round_count <= cfg_data[RC_W-1:0];
            keys_ready  <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // block words, schedule working values and result register
  always_ff @(posedge clk) begin
    case (state)
      IDLE: begin
        if (blk_acc) begin
          func_q <= func_in;
          wa     <= blk.word_a;
          wb     <= blk.word_b;
          wc     <= blk.word_c;
          wd     <= blk.word_d;
          ks_a   <= '0;
          ks_b   <= '0;
          prun   <= P32;
          for (int jj = 0; jj < KW_DEPTH; jj++) begin
            key_work[jj] <= kw_init[jj];
          end
        end
      end
      KS_INIT: prun <= prun + Q32;
      KS_A:    ks_a <= ks_anew;
      KS_B: begin
        ks_b         <= ks_bnew;
        key_work[kj] <= ks_bnew;
      end
      WHITE: begin
        if (enc) begin
          wb <= wb + rk_even_q;
          wd <= wd + rk_odd_q;
        end else begin
          // undo the final whitening, then rotate words ahead of the last round
          wa <= wd;
          wb <= wa - rk_even_q;
          wc <= wb;
          wd <= wc - rk_odd_q;
        end
      end
      MIX: begin
        t_q <= quad_mix(wb);
        u_q <= quad_mix(wd);
      end
      ROUND: begin
        if (enc) begin
          wa <= wb;
          wb <= enc_c;
          wc <= wd;
          wd <= enc_a;
        end else if (rnd_last) begin
          wa <= dec_a;
          wc <= dec_c;
        end else begin
          wa <= wd;
          wb <= dec_a;
          wc <= wb;
          wd <= dec_c;
        end
      end
      FIN: begin
        if (res_load) begin
          if (enc) begin
            res_a <= wa + rk_even_q;
            res_b <= wb;
            res_c <= wc + rk_odd_q;
            res_d <= wd;
          end else begin
            res_a <= wa;
            res_b <= wb - rk_even_q;
            res_c <= wc;
            res_d <= wd - rk_odd_q;
          end
        end
      end
      default: ;
    endcase
  end

endmodule
